// File: hdl/fct_pkg.sv
// Shared constants and codes for the Fenwick count tree.
package fct_pkg;

    // Payload field widths
    localparam int POS_W    = 11;
    localparam int COUNT_W  = 32;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 1;

    // Stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = ((POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((COUNT_W + STATUS_W + 7) / 8) * 8;

    // Default number of tree positions
    localparam int TREE_SIZE_DEF = 1024;

    // Operation codes carried in the input tuser
    localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVF   = 2'd2;

endpackage

// File: hdl/fct_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/fenwick_count_tree.sv
// Top level of the Fenwick count tree: walk sequencer around one cell memory.
//
// Binary indexed tree of 32-bit occurrence counts over positions 1..TREE_SIZE.
// An input item with tuser = 0 inserts one at the position in tdata; tuser = 1
// returns the count of inserts at positions 1..position. Each item yields
// exactly one result item with the count (0 for inserts) and a status:
// 0 ok, 1 position out of range (insert ignored, query saturated to
// TREE_SIZE), 2 some cell has wrapped past 2^32-1 since reset. After reset
// the block sweeps the cell memory to zero, one entry per cycle, before
// s_tready first rises. Items are handled one at a time: the walk visits up
// to log2(TREE_SIZE)+1 cells at one memory access per cycle (read of the
// next cell overlaps write-back of the current one); the item is accepted in
// the idle state and the result then waits in the done state until the
// output register is free. The next item is taken while a result still
// waits on the output.
module fenwick_count_tree #(
    parameter int TREE_SIZE = fct_pkg::TREE_SIZE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fct_pkg::IN_DATA_W-1:0]  s_tdata,   // [10:0] position
    input  logic [fct_pkg::MODE_W-1:0]     s_tuser,   // [0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fct_pkg::OUT_DATA_W-1:0] m_tdata    // [31:0] prefix_count, [33:32] status
);

    import fct_pkg::*;

    localparam int ADDR_W = $clog2(TREE_SIZE);
    localparam int WALK_W = $clog2(TREE_SIZE) + 2;
    localparam int PAD_W  = OUT_DATA_W - COUNT_W - STATUS_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]            state_reg,  state_next;
    logic [ADDR_W-1:0]     clr_reg,    clr_next;
    logic [WALK_W-1:0]     cur_reg,    cur_next;
    logic [MODE_W-1:0]     mode_reg,   mode_next;
    logic                  bad_reg,    bad_next;
    logic                  ovf_reg,    ovf_next;
    logic [COUNT_W-1:0]    acc_reg,    acc_next;
    logic                  mvalid_reg, mvalid_next;
    logic [OUT_DATA_W-1:0] mdata_reg,  mdata_next;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_W-1:0]    wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [COUNT_W-1:0]    rd_data;

    logic [POS_W-1:0]      pos_in;
    logic                  pos_over;
    logic                  in_bad;
    logic [WALK_W-1:0]     start_pos;
    logic                  start_walk;
    logic [WALK_W-1:0]     low_bit;
    logic [WALK_W-1:0]     nxt_pos;
    logic                  nxt_more;
    logic                  out_free;
    logic [STATUS_W-1:0]   status;

    // Cell memory
    fct_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TREE_SIZE)
    ) u_cells (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Decode the incoming item
    always_comb
    begin
        pos_in    = s_tdata[POS_W-1:0];
        pos_over  = 32'(pos_in) > 32'(TREE_SIZE);
        start_pos = pos_over ? WALK_W'(TREE_SIZE) : WALK_W'(pos_in);
        if (s_tuser == MODE_INSERT)
        begin
            in_bad     = pos_over || (pos_in == '0);
            start_walk = !in_bad;
        end
        else
        begin
            in_bad     = pos_over;
            start_walk = start_pos != '0;
        end
    end

    // Step along the lowest-set-bit chain
    always_comb
    begin
        low_bit = cur_reg & (~cur_reg + WALK_W'(1));
        if (mode_reg == MODE_INSERT)
        begin
            nxt_pos  = cur_reg + low_bit;
            nxt_more = nxt_pos <= WALK_W'(TREE_SIZE);
        end
        else
        begin
            nxt_pos  = cur_reg & (cur_reg - WALK_W'(1));
            nxt_more = nxt_pos != '0;
        end
    end

    assign out_free = !mvalid_reg || m_tready;
    assign status   = bad_reg ? STATUS_RANGE : (ovf_reg ? STATUS_OVF : STATUS_OK);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cur_next    = cur_reg;
        mode_next   = mode_reg;
        bad_next    = bad_reg;
        ovf_next    = ovf_reg;
        acc_next    = acc_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        wr_en       = 1'b0;
        wr_addr     = ADDR_W'(cur_reg - WALK_W'(1));
        wr_data     = rd_data + COUNT_W'(1);
        rd_en       = 1'b0;
        rd_addr     = ADDR_W'(nxt_pos - WALK_W'(1));
        s_tready    = 1'b0;

        // Drop a delivered result
        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(TREE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    mode_next = s_tuser;
                    bad_next  = in_bad;
                    acc_next  = '0;
                    cur_next  = start_pos;
                    if (start_walk)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(start_pos - WALK_W'(1));
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WALK:
            begin
                // Write back or accumulate the current cell, fetch the next
                if (mode_reg == MODE_INSERT)
                begin
                    wr_en = 1'b1;
                    if (rd_data == '1)
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    acc_next = acc_reg + rd_data;
                end
                cur_next = nxt_pos;
                if (nxt_more)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register is free
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {PAD_W'(0), status, acc_reg};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovf_reg    <= ovf_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        mode_reg  <= mode_next;
        bad_reg   <= bad_next;
        acc_reg   <= acc_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

// File: hdl/fct_checker.sv
// Port-level checker for the Fenwick count tree, bound to the top level.
module fct_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [fct_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic [fct_pkg::MODE_W-1:0]     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fct_pkg::OUT_DATA_W-1:0] m_tdata
);

    import fct_pkg::*;

    logic [STATUS_W-1:0] out_status;

    assign out_status = m_tdata[COUNT_W +: STATUS_W];

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Hold an offered item until it is taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting input item changed");

    // Report only defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_status == STATUS_OK) || (out_status == STATUS_RANGE)
                     || (out_status == STATUS_OVF))
        else $error("undefined status code");

    // Work on one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in progress");

    // Keep the padding above the status field at zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:COUNT_W+STATUS_W] == '0)
        else $error("result padding not zero");

endmodule

bind fenwick_count_tree fct_checker u_fct_checker (.*);

// File: sim/tb_fenwick_count_tree.sv
// Self-checking testbench for the Fenwick count tree: directed and random insert/query items.
`timescale 1ns / 100ps

module tb_fenwick_count_tree;

    import fct_pkg::*;

    localparam int TREE_N         = TREE_SIZE_DEF;
    localparam int RANDOM_ITEMS   = 500;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 24;

    // One result item as the block reports it
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } tree_result_t;

    // Shadow copy of the tree; predicts one result per accepted item
    class fenwick_board;
        bit [COUNT_W-1:0] cells [1:TREE_N];
        bit               wrapped;
        tree_result_t     awaited[$];
        int unsigned      errors;

        function new();
            foreach (cells[i])
                cells[i] = '0;
            wrapped = 1'b0;
            errors  = 0;
        endfunction

        // Apply an accepted item to the shadow tree and queue its result
        function void note_item(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos);
            int unsigned  p;
            bit [COUNT_W-1:0] sum;
            bit           bad;
            tree_result_t res;
            p   = pos;
            sum = '0;
            bad = 1'b0;
            if (mode == MODE_INSERT)
            begin
                if (p == 0 || p > TREE_N)
                    bad = 1'b1;
                else
                begin
                    // Walk upward along the lowest-set-bit chain
                    while (p >= 1 && p <= TREE_N)
                    begin
                        if (cells[p] == '1)
                            wrapped = 1'b1;
                        cells[p] = cells[p] + 1'b1;
                        p = p + (p & (~p + 1));
                    end
                end
            end
            else
            begin
                // Saturate an oversize query, then sum downward
                if (p > TREE_N)
                begin
                    bad = 1'b1;
                    p   = TREE_N;
                end
                while (p > 0)
                begin
                    sum = sum + cells[p];
                    p = p - (p & (~p + 1));
                end
            end
            res.count  = sum;
            res.status = bad ? STATUS_RANGE : (wrapped ? STATUS_OVF : STATUS_OK);
            awaited = {awaited, res};
        endfunction

        // Compare an accepted result with the oldest prediction
        function void check_result(logic [COUNT_W-1:0] count, logic [STATUS_W-1:0] status);
            tree_result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result count %0d status %0d", $time, count, status);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (count !== want.count)
            begin
                $display("%0t: prefix_count mismatch, expected %0d, actual %0d",
                         $time, want.count, count);
                errors++;
            end
            if (status !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    fenwick_board board;
    int unsigned  burst_left;
    int unsigned  stall_left  = 0;
    int unsigned  stall_style = 0;
    int unsigned  idle_cycles = 0;

    fenwick_count_tree #(
        .TREE_SIZE (TREE_N)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Score both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata[COUNT_W-1:0], m_tdata[COUNT_W +: STATUS_W]);
        if (rst_n && s_tvalid && s_tready)
            board.note_item(s_tuser, s_tdata[POS_W-1:0]);
    end

    // Receiver: drive m_tready in a random stall style, switching style at random
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(16, 96);
        end
        else
            stall_left--;
        case (stall_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 5) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_fenwick_count_tree: errors");
            $finish;
        end
    end

    // Offer one item at a falling edge, after a random gap at the start of a burst, and hold it until accepted
    task automatic send_item(input logic [MODE_W-1:0] mode, input int unsigned pos);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= IN_DATA_W'(pos[POS_W-1:0]);
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Pick a random operation, mostly valid inserts and queries
    task automatic random_op(output logic [MODE_W-1:0] mode, output int unsigned pos);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            mode = MODE_INSERT;
            pos  = $urandom_range(1, 32);
        end
        else if (pick < 47)
        begin
            mode = MODE_INSERT;
            pos  = $urandom_range(1, TREE_N);
        end
        else if (pick < 87)
        begin
            mode = MODE_QUERY;
            pos  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom_range(0, TREE_N);
        end
        else if (pick < 94)
        begin
            mode = MODE_INSERT;
            pos  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(TREE_N + 1, 2047);
        end
        else
        begin
            mode = MODE_QUERY;
            pos  = $urandom_range(TREE_N + 1, 2047);
        end
    endtask

    initial
    begin
        logic [MODE_W-1:0] mode;
        int unsigned       pos;
        board       = new();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = MODE_INSERT;
        s_tdata     = '0;
        burst_left  = 0;

        // Hold reset, release at a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty tree, query extremes and oversize query
        send_item(MODE_QUERY, 0);
        send_item(MODE_QUERY, 1);
        send_item(MODE_QUERY, TREE_N);
        send_item(MODE_QUERY, 2047);
        // Out-of-range inserts leave the tree untouched
        send_item(MODE_INSERT, 0);
        send_item(MODE_INSERT, TREE_N + 1);
        send_item(MODE_INSERT, 2047);
        // Inserts at the ends, at powers of two and at odd spots
        send_item(MODE_INSERT, 1);
        send_item(MODE_INSERT, TREE_N);
        send_item(MODE_INSERT, 2);
        send_item(MODE_INSERT, 3);
        send_item(MODE_INSERT, 512);
        send_item(MODE_INSERT, 1023);
        send_item(MODE_INSERT, 1);
        // Prefix sums across the chain boundaries
        send_item(MODE_QUERY, 1);
        send_item(MODE_QUERY, 2);
        send_item(MODE_QUERY, 3);
        send_item(MODE_QUERY, 511);
        send_item(MODE_QUERY, 512);
        send_item(MODE_QUERY, 1023);
        send_item(MODE_QUERY, TREE_N);
        send_item(MODE_QUERY, TREE_N + 1);
        send_item(MODE_QUERY, 0);
        send_item(MODE_INSERT, 0);

        // Random mix; a cell needs 2^32 inserts to wrap, so overflow stays clear
        repeat (RANDOM_ITEMS)
        begin
            random_op(mode, pos);
            send_item(mode, pos);
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("tb_fenwick_count_tree: clean");
        else
            $display("tb_fenwick_count_tree: errors");
        $finish;
    end

endmodule
